[design/adaptive_binary_count_model_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive binary count model unit.
// Each macro builds one labelled concurrent assertion clocked on the rising
// edge and switched off while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_BINARY_COUNT_MODEL_UNIT_MACROS_SVH
`define ADAPTIVE_BINARY_COUNT_MODEL_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABCM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/abcm_pkg.sv]
// ----------------------------------------------------------------------------
// abcm_pkg
// Constants, types and function codes of the adaptive binary count model.
// ----------------------------------------------------------------------------
package abcm_pkg;

    localparam int CONTEXT_SLOTS   = 1024;
    localparam int ENTRY_COUNT     = CONTEXT_SLOTS + 2;
    localparam int BYPASS_INDEX    = CONTEXT_SLOTS;
    localparam int TERMINATE_INDEX = CONTEXT_SLOTS + 1;

    // Field widths of one input word and one result word.
    localparam int FUNC_W  = 2;
    localparam int CTX_W   = 11;
    localparam int RANGE_W = 64;

    // Counts stay within 194, so eight bits hold them.
    localparam int COUNT_W = 8;
    localparam int IDX_W   = $clog2(ENTRY_COUNT);
    localparam int ENTRY_W = 2 * COUNT_W;
    localparam int STEP_W  = $clog2(RANGE_W);

    // Compare width for the context range check.
    localparam int CNT1_W  = $clog2(ENTRY_COUNT + 1);
    localparam int CMP_W   = (CTX_W > CNT1_W) ? CTX_W : CNT1_W;

    localparam int HALVE_LIMIT     = 'h60;
    localparam int TERMINATE_ZEROS = 'h180 / 2;

    typedef logic [FUNC_W-1:0]  t_func;
    typedef logic [CTX_W-1:0]   t_ctx;
    typedef logic [RANGE_W-1:0] t_range;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [IDX_W-1:0]   t_idx;

    localparam t_func FUNC_CLEAR  = 2'd0;
    localparam t_func FUNC_QUERY  = 2'd1;
    localparam t_func FUNC_UPDATE = 2'd2;

    localparam t_count COUNT_ONE       = COUNT_W'(1);
    localparam t_count COUNT_TERM_ZERO = COUNT_W'(TERMINATE_ZEROS);
    localparam t_idx   IDX_TERMINATE   = IDX_W'(TERMINATE_INDEX);
    localparam t_idx   IDX_LAST        = IDX_W'(ENTRY_COUNT - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RANGE_W - 1);

endpackage

[design/abcm_ram.sv]
// ----------------------------------------------------------------------------
// abcm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module abcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/adaptive_binary_count_model_unit.sv]
// ----------------------------------------------------------------------------
// adaptive_binary_count_model_unit
// Query: the result comes from the restoring divider loop
// (table read, 64 radix-2 steps of the divide unit, one multiply).
// Update: read, modify and write of the count RAM. Clear: a new clearing pass.
// Other words: a zero result. The next word is taken once the result leaves.
// After reset a clearing pass writes default counts to all 1026 entries,
// during which no word is accepted.
// ----------------------------------------------------------------------------
`include "adaptive_binary_count_model_unit_macros.svh"

module adaptive_binary_count_model_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  abcm_pkg::t_func i_func,
    input  abcm_pkg::t_ctx  i_context_index,
    input  abcm_pkg::t_range i_range_value,
    input  logic            i_symbol_bit,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output abcm_pkg::t_range o_split_value
);

    import abcm_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        r_state,     n_state;
    t_idx              r_clr_idx,   n_clr_idx;
    logic              r_clr_item,  n_clr_item;
    t_func             r_func,      n_func;
    logic              r_sym,       n_sym;
    t_idx              r_idx,       n_idx;
    t_count            r_ones,      n_ones;
    t_count            r_div,       n_div;
    t_count            r_rem,       n_rem;
    t_range            r_work,      n_work;
    logic [STEP_W-1:0] r_step,      n_step;
    t_range            r_result,    n_result;
    logic              r_out_valid, n_out_valid;
    t_range            r_out_data,  n_out_data;

    logic               ram_we;
    t_idx               ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [CMP_W-1:0]     w_ctx_ext;
    logic                 w_in_ok;
    t_idx                 w_in_idx;
    logic                 w_accept;
    t_count               w_rd_ones;
    t_count               w_rd_zeros;
    logic [COUNT_W:0]     w_total;
    logic [COUNT_W:0]     w_ones_inc;
    logic [COUNT_W:0]     w_zeros_inc;
    logic [COUNT_W+1:0]   w_inc_sum;
    logic [COUNT_W+1:0]   w_ones_half;
    logic [COUNT_W+1:0]   w_zeros_half;
    t_count               w_ones_new;
    t_count               w_zeros_new;
    logic [COUNT_W:0]     w_trial;
    logic                 w_ge;
    logic [COUNT_W:0]     w_trial_sub;
    logic [RANGE_W+COUNT_W-1:0] w_prod;
    t_count               w_clr_zeros;

    assign w_ctx_ext = CMP_W'(i_context_index);
    assign w_in_ok   = (w_ctx_ext < CMP_W'(ENTRY_COUNT));
    assign w_in_idx  = w_ctx_ext[IDX_W-1:0];
    assign w_accept  = i_in_valid && o_in_ready;

    assign w_rd_ones  = ram_rdata[ENTRY_W-1:COUNT_W];
    assign w_rd_zeros = ram_rdata[COUNT_W-1:0];
    assign w_total    = {1'b0, w_rd_ones} + {1'b0, w_rd_zeros};

    // Count update: bump the coded symbol, then halve both with rounding up when their sum exceeds the limit.
    assign w_ones_inc   = {1'b0, w_rd_ones} + (COUNT_W + 1)'(r_sym);
    assign w_zeros_inc  = {1'b0, w_rd_zeros} + (COUNT_W + 1)'(!r_sym);
    assign w_inc_sum    = {1'b0, w_ones_inc} + {1'b0, w_zeros_inc};
    assign w_ones_half  = ({1'b0, w_ones_inc} + (COUNT_W + 2)'(1)) >> 1;
    assign w_zeros_half = ({1'b0, w_zeros_inc} + (COUNT_W + 2)'(1)) >> 1;
    assign w_ones_new   = (w_inc_sum > (COUNT_W + 2)'(HALVE_LIMIT))
                        ? w_ones_half[COUNT_W-1:0] : w_ones_inc[COUNT_W-1:0];
    assign w_zeros_new  = (w_inc_sum > (COUNT_W + 2)'(HALVE_LIMIT))
                        ? w_zeros_half[COUNT_W-1:0] : w_zeros_inc[COUNT_W-1:0];

    // One restoring divide step: the remainder always stays below the divisor.
    assign w_trial     = {r_rem, r_work[RANGE_W-1]};
    assign w_ge        = (w_trial >= {1'b0, r_div});
    assign w_trial_sub = w_trial - {1'b0, r_div};

    assign w_prod = (RANGE_W + COUNT_W)'(r_work) * (RANGE_W + COUNT_W)'(r_ones);

    assign w_clr_zeros = (r_clr_idx == IDX_TERMINATE) ? COUNT_TERM_ZERO : COUNT_ONE;

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_clr_item  = r_clr_item;
        n_func      = r_func;
        n_sym       = r_sym;
        n_idx       = r_idx;
        n_ones      = r_ones;
        n_div       = r_div;
        n_rem       = r_rem;
        n_work      = r_work;
        n_step      = r_step;
        n_result    = r_result;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = {w_ones_new, w_zeros_new};

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = {COUNT_ONE, w_clr_zeros};
                n_clr_idx = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_LAST) begin
                    n_clr_item = 1'b0;
                    n_state    = r_clr_item ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func   = i_func;
                    n_sym    = i_symbol_bit;
                    n_idx    = w_in_idx;
                    n_work   = i_range_value;
                    n_result = '0;
                    if (i_func == FUNC_CLEAR) begin
                        n_clr_idx  = '0;
                        n_clr_item = 1'b1;
                        n_state    = S_INIT;
                    end else if ((i_func == FUNC_QUERY || i_func == FUNC_UPDATE)
                                 && w_in_ok) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOAD: begin
                if (r_func == FUNC_UPDATE) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_ones  = w_rd_ones;
                    n_div   = w_total[COUNT_W-1:0];
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = w_ge ? w_trial_sub[COUNT_W-1:0] : w_trial[COUNT_W-1:0];
                n_work = {r_work[RANGE_W-2:0], w_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_result = (r_div == '0) ? '0 : w_prod[RANGE_W-1:0];
                n_state  = S_DONE;
            end
            S_DONE: begin
                // The result waits here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_idx   <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_item  <= n_clr_item;
            r_out_valid <= n_out_valid;
        end
        r_func     <= n_func;
        r_sym      <= n_sym;
        r_idx      <= n_idx;
        r_ones     <= n_ones;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_work     <= n_work;
        r_step     <= n_step;
        r_result   <= n_result;
        r_out_data <= n_out_data;
    end

    abcm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRY_COUNT)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (w_in_idx),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_split_value = r_out_data;

    `ABCM_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_div != '0, "divisor is zero during division")
    `ABCM_ASSERT_NOW(a_no_write_in_div, i_clk, i_rst_n, r_state == S_DIV, !ram_we, "count RAM written during division")
    `ABCM_ASSERT_NOW(a_zero_non_query, i_clk, i_rst_n, r_state == S_DONE && r_func != FUNC_QUERY, r_result == '0, "non-zero result for a word that is not a query")
    `ABCM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, r_state != S_IDLE, "sequencer still idle after accepting a word")

endmodule
